### hdl/fcpid_pkg.sv
`timescale 1ns / 1ps

package fcpid_pkg;

    localparam int CH_W          = 2;
    localparam int NUM_GAIN_SETS = 4;
    localparam int SPD_W         = 16;
    localparam int GAIN_W        = 16;
    localparam int GAINS_W       = 3 * GAIN_W;
    localparam int KP_LSB        = 0;
    localparam int KI_LSB        = GAIN_W;
    localparam int KD_LSB        = 2 * GAIN_W;
    localparam int DUTY_W        = 16;
    localparam int DIR_W         = 2;
    localparam int ERR_W         = SPD_W + 1;
    localparam int DERR_W        = ERR_W + 1;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = GAINS_W;

    localparam int OUT_FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W     = $clog2(OUT_FIFO_DEPTH);
    localparam int FIFO_CNT_W     = $clog2(OUT_FIFO_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAINS_CH0 = 3'd0,
        REG_GAINS_CH1 = 3'd1,
        REG_GAINS_CH2 = 3'd2,
        REG_GAINS_CH3 = 3'd3,
        REG_DUTY_LO   = 3'd4,
        REG_DUTY_HI   = 3'd5
    } cfg_reg_t;

    typedef enum logic [DIR_W-1:0] {
        DIR_FORWARD = 2'd0,
        DIR_REVERSE = 2'd1,
        DIR_BRAKE   = 2'd2
    } dir_t;

    typedef logic [NUM_GAIN_SETS-1:0][GAINS_W-1:0] gain_bank_t;

    typedef struct packed {
        logic [DUTY_W-1:0] lo;
        logic [DUTY_W-1:0] hi;
    } duty_limits_t;

    typedef struct packed {
        logic            valid;
        logic            chan_ok;
        logic [CH_W-1:0] channel;
        dir_t            direction;
    } tick_ctl_t;

    typedef struct packed {
        logic [CH_W-1:0]   channel;
        logic [DUTY_W-1:0] duty;
        dir_t              direction;
    } result_t;

endpackage

### hdl/fcpid_ifs.sv
`timescale 1ns / 1ps

interface fcpid_tick_if
    import fcpid_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [CH_W-1:0]         channel;
    logic signed [SPD_W-1:0] setpoint;
    logic signed [SPD_W-1:0] measured_speed;
    logic                    reset_integral;

    modport source (
        output valid, channel, setpoint, measured_speed, reset_integral,
        input  ready
    );
    modport sink (
        input  valid, channel, setpoint, measured_speed, reset_integral,
        output ready
    );
endinterface

interface fcpid_drive_if
    import fcpid_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CH_W-1:0]   out_channel;
    logic [DUTY_W-1:0] duty;
    logic [DIR_W-1:0]  direction;

    modport source (
        output valid, out_channel, duty, direction,
        input  ready
    );
    modport sink (
        input  valid, out_channel, duty, direction,
        output ready
    );
endinterface

interface fcpid_cfg_if
    import fcpid_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

### hdl/four_channel_pid_motor_speed_core.sv
`timescale 1ns / 1ps

// Four-channel PID speed controller for motor PWM.
// tick:  one beat per control tick: channel, signed setpoint, measured speed and
//        an integrator-clear flag. Accepted when valid and ready are both high.
// drive: one beat per tick, in order: channel, clamped duty and direction
//        (forward, reverse, brake on a zero setpoint).
// cfg:   register writes (index 0..3 packed P/I/D gains per channel, 4 lower duty
//        limit, 5 upper duty limit); always ready, write only while no tick is in flight.
// A tick passes through state read/modify/write, multiply, then sum and clamp, and
// its result is buffered before it is offered. Throughput: one tick per cycle while
// tick.ready is high, including back-to-back ticks on the same channel; the per-channel
// state memory is written in the cycle after it is read and the new entry is forwarded.
// The output side holds up to 8 results; tick.ready drops only when 8 accepted
// ticks have not yet left on drive, so a stalled receiver backs up the input
// after 8 beats and nothing is lost.
// Reset clears gains to zero, duty limits to 0..65535 and every channel's
// previous error and error sum to zero at once; ticks are taken right after.

module four_channel_pid_motor_speed_core
    import fcpid_pkg::*;
#(
    parameter int CHANNELS       = 4,
    parameter int COEF_FRAC_BITS = 12,
    parameter int SUM_WIDTH      = 32
) (
    input logic          clk,
    input logic          rst_n,
    fcpid_tick_if.sink   tick,
    fcpid_drive_if.source drive,
    fcpid_cfg_if.sink    cfg
);

    gain_bank_t   gains;
    duty_limits_t limits;

    logic                        tick_accept;
    logic                        tick_room;
    tick_ctl_t                   st_ctl;
    logic signed [ERR_W-1:0]     st_err;
    logic signed [DERR_W-1:0]    st_derr;
    logic signed [SUM_WIDTH-1:0] st_sum;
    logic                        res_valid;
    result_t                     res;
    result_t                     head;

    assign cfg.ready   = 1'b1;
    assign tick.ready  = tick_room;
    assign tick_accept = tick.valid && tick_room;

    fcpid_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .gains    (gains),
        .limits   (limits)
    );

    fcpid_state_mem #(
        .CHANNELS  (CHANNELS),
        .SUM_WIDTH (SUM_WIDTH)
    ) u_state_mem (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (tick_accept),
        .channel        (tick.channel),
        .setpoint       (tick.setpoint),
        .measured_speed (tick.measured_speed),
        .reset_integral (tick.reset_integral),
        .ctl            (st_ctl),
        .err            (st_err),
        .derr           (st_derr),
        .err_sum        (st_sum)
    );

    fcpid_pid_math #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .SUM_WIDTH      (SUM_WIDTH)
    ) u_pid_math (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (st_ctl),
        .err       (st_err),
        .derr      (st_derr),
        .err_sum   (st_sum),
        .gains     (gains),
        .limits    (limits),
        .res_valid (res_valid),
        .res       (res)
    );

    fcpid_out_fifo u_out_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_accept (tick_accept),
        .tick_room   (tick_room),
        .wr_en       (res_valid),
        .wr_data     (res),
        .rd_valid    (drive.valid),
        .rd_ready    (drive.ready),
        .rd_data     (head)
    );

    assign drive.out_channel = head.channel;
    assign drive.duty        = head.duty;
    assign drive.direction   = head.direction;

endmodule

### hdl/fcpid_cfg_regs.sv
`timescale 1ns / 1ps

module fcpid_cfg_regs
    import fcpid_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output gain_bank_t            gains,
    output duty_limits_t          limits
);

    gain_bank_t   gains_reg;
    duty_limits_t limits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg     <= '0;
            limits_reg.lo <= '0;
            limits_reg.hi <= '1;
        end
        else if (wr_en)
        begin
            unique case (wr_index) inside
                REG_GAINS_CH0, REG_GAINS_CH1, REG_GAINS_CH2, REG_GAINS_CH3:
                    gains_reg[wr_index[CH_W-1:0]] <= wr_data;
                REG_DUTY_LO:
                    limits_reg.lo <= wr_data[DUTY_W-1:0];
                REG_DUTY_HI:
                    limits_reg.hi <= wr_data[DUTY_W-1:0];
                default:
                    ; // unmapped index: drop the beat
            endcase
        end
    end

    assign gains  = gains_reg;
    assign limits = limits_reg;

endmodule

### hdl/fcpid_state_mem.sv
`timescale 1ns / 1ps

module fcpid_state_mem
    import fcpid_pkg::*;
#(
    parameter int CHANNELS  = 4,
    parameter int SUM_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [CH_W-1:0]             channel,
    input  logic signed [SPD_W-1:0]     setpoint,
    input  logic signed [SPD_W-1:0]     measured_speed,
    input  logic                        reset_integral,
    output tick_ctl_t                   ctl,
    output logic signed [ERR_W-1:0]     err,
    output logic signed [DERR_W-1:0]    derr,
    output logic signed [SUM_WIDTH-1:0] err_sum
);

    localparam int STATE_DEPTH = (CHANNELS < NUM_GAIN_SETS) ? CHANNELS : NUM_GAIN_SETS;
    localparam int ADDR_W      = (STATE_DEPTH > 1) ? $clog2(STATE_DEPTH) : 1;
    localparam int ENTRY_W     = SUM_WIDTH + ERR_W;

    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    // per-channel state: {error_sum, previous_error}
    logic [ENTRY_W-1:0]     mem [STATE_DEPTH];
    logic [STATE_DEPTH-1:0] entry_valid_reg;

    logic [ENTRY_W-1:0]      rd_q_reg;
    logic                    rd_valid_reg;
    tick_ctl_t               s1_ctl_reg;
    tick_ctl_t               s1_ctl_next;
    logic signed [SPD_W-1:0] s1_sp_reg;
    logic signed [SPD_W-1:0] s1_pv_reg;
    logic                    s1_clr_reg;

    tick_ctl_t                   s2_ctl_reg;
    logic signed [ERR_W-1:0]     s2_err_reg;
    logic signed [DERR_W-1:0]    s2_derr_reg;
    logic signed [SUM_WIDTH-1:0] s2_sum_reg;

    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] s1_addr;
    logic              chan_ok;
    dir_t              dir_in;

    logic                        fwd_hit;
    logic [ENTRY_W-1:0]          old_entry;
    logic signed [ERR_W-1:0]     prev_err;
    logic signed [SUM_WIDTH-1:0] old_sum;
    logic signed [ERR_W-1:0]     sp_ext;
    logic signed [ERR_W-1:0]     pv_ext;
    logic signed [ERR_W-1:0]     sp_mag;
    logic signed [ERR_W-1:0]     pv_mag;
    logic signed [ERR_W-1:0]     err_next;
    logic signed [DERR_W-1:0]    derr_next;
    logic signed [SUM_WIDTH:0]   sum_wide;
    logic signed [SUM_WIDTH-1:0] sum_next;
    logic                        wr_en;

    assign rd_addr = channel[ADDR_W-1:0];
    assign chan_ok = (int'(channel) < CHANNELS);

    always_comb
    begin
        if (setpoint < 0)
            dir_in = DIR_REVERSE;
        else if (setpoint == 0)
            dir_in = DIR_BRAKE;
        else
            dir_in = DIR_FORWARD;
    end

    always_comb
    begin
        s1_ctl_next.valid     = accept;
        s1_ctl_next.chan_ok   = chan_ok;
        s1_ctl_next.channel   = channel;
        s1_ctl_next.direction = dir_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg   <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_ctl_reg <= s1_ctl_next;
            if (accept)
                rd_valid_reg <= entry_valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sp_reg  <= setpoint;
            s1_pv_reg  <= measured_speed;
            s1_clr_reg <= reset_integral;
        end
    end

    // read-modify-write of the channel entry
    assign s1_addr = s1_ctl_reg.channel[ADDR_W-1:0];

    // the entry written at the edge that launched this read is still stale in rd_q_reg
    assign fwd_hit = s2_ctl_reg.valid && s2_ctl_reg.chan_ok &&
                     (s2_ctl_reg.channel[ADDR_W-1:0] == s1_addr);

    always_comb
    begin
        if (fwd_hit)
            old_entry = {s2_sum_reg, s2_err_reg};
        else if (rd_valid_reg)
            old_entry = rd_q_reg;
        else
            old_entry = '0;
    end

    assign prev_err = old_entry[ERR_W-1:0];
    assign old_sum  = old_entry[ENTRY_W-1:ERR_W];

    assign sp_ext   = ERR_W'(s1_sp_reg);
    assign pv_ext   = ERR_W'(s1_pv_reg);
    assign sp_mag   = sp_ext[ERR_W-1] ? -sp_ext : sp_ext;
    assign pv_mag   = pv_ext[ERR_W-1] ? -pv_ext : pv_ext;
    assign err_next = sp_mag - pv_mag;

    assign derr_next = DERR_W'(err_next) - DERR_W'(prev_err);
    assign sum_wide  = (SUM_WIDTH+1)'(old_sum) + (SUM_WIDTH+1)'(err_next);

    always_comb
    begin
        if (s1_clr_reg)
            sum_next = '0;
        else if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1])
            sum_next = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
        else
            sum_next = sum_wide[SUM_WIDTH-1:0];
    end

    assign wr_en = s1_ctl_reg.valid && s1_ctl_reg.chan_ok;

    always_ff @(posedge clk)
    begin
        if (accept)
            rd_q_reg <= mem[rd_addr];
        if (wr_en)
            mem[s1_addr] <= {sum_next, err_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            s2_ctl_reg      <= '0;
        end
        else
        begin
            if (wr_en)
                entry_valid_reg[s1_addr] <= 1'b1;
            s2_ctl_reg <= s1_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_err_reg  <= err_next;
        s2_derr_reg <= derr_next;
        s2_sum_reg  <= sum_next;
    end

    assign ctl     = s2_ctl_reg;
    assign err     = s2_err_reg;
    assign derr    = s2_derr_reg;
    assign err_sum = s2_sum_reg;

endmodule

### hdl/fcpid_pid_math.sv
`timescale 1ns / 1ps

module fcpid_pid_math
    import fcpid_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 12,
    parameter int SUM_WIDTH      = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tick_ctl_t                   ctl,
    input  logic signed [ERR_W-1:0]     err,
    input  logic signed [DERR_W-1:0]    derr,
    input  logic signed [SUM_WIDTH-1:0] err_sum,
    input  gain_bank_t                  gains,
    input  duty_limits_t                limits,
    output logic                        res_valid,
    output result_t                     res
);

    localparam int PROD_P_W = GAIN_W + ERR_W;
    localparam int PROD_D_W = GAIN_W + DERR_W;
    localparam int PROD_I_W = GAIN_W + SUM_WIDTH;
    localparam int ACC_W    = PROD_I_W + 2;

    logic [GAINS_W-1:0]       gain_sel;
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;

    tick_ctl_t                  s3_ctl_reg;
    logic signed [PROD_P_W-1:0] p_reg;
    logic signed [PROD_D_W-1:0] d_reg;
    logic signed [PROD_I_W-1:0] i_reg;

    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] shifted;
    logic signed [ACC_W-1:0] lo_ext;
    logic signed [ACC_W-1:0] hi_ext;
    logic [DUTY_W-1:0]       duty;

    assign gain_sel = gains[ctl.channel];
    assign kp       = gain_sel[KP_LSB +: GAIN_W];
    assign ki       = gain_sel[KI_LSB +: GAIN_W];
    assign kd       = gain_sel[KD_LSB +: GAIN_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_ctl_reg <= '0;
        else
            s3_ctl_reg <= ctl;
    end

    always_ff @(posedge clk)
    begin
        p_reg <= PROD_P_W'(kp) * PROD_P_W'(err);
        d_reg <= PROD_D_W'(kd) * PROD_D_W'(derr);
        i_reg <= PROD_I_W'(ki) * PROD_I_W'(err_sum);
    end

    // arithmetic shift floors toward minus infinity; clamp at full width
    assign acc     = ACC_W'(p_reg) + ACC_W'(d_reg) + ACC_W'(i_reg);
    assign shifted = acc >>> COEF_FRAC_BITS;
    assign lo_ext  = ACC_W'($signed({1'b0, limits.lo}));
    assign hi_ext  = ACC_W'($signed({1'b0, limits.hi}));

    always_comb
    begin
        if (!s3_ctl_reg.chan_ok)
            duty = '0;
        else if (shifted < lo_ext)
            duty = limits.lo;
        else if (shifted > hi_ext)
            duty = limits.hi;
        else
            duty = shifted[DUTY_W-1:0];
    end

    assign res_valid     = s3_ctl_reg.valid;
    assign res.channel   = s3_ctl_reg.channel;
    assign res.duty      = duty;
    assign res.direction = s3_ctl_reg.direction;

endmodule

### hdl/fcpid_out_fifo.sv
`timescale 1ns / 1ps

module fcpid_out_fifo
    import fcpid_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    tick_accept,
    output logic    tick_room,
    input  logic    wr_en,
    input  result_t wr_data,
    output logic    rd_valid,
    input  logic    rd_ready,
    output result_t rd_data
);

    result_t buf_mem [OUT_FIFO_DEPTH];

    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic [FIFO_CNT_W-1:0] credit_reg;
    logic [FIFO_CNT_W-1:0] credit_next;
    logic                  pop;

    assign rd_valid = (count_reg != '0);
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = buf_mem[rd_ptr_reg];

    // credits cover beats in the pipeline as well as those held here
    assign tick_room   = (credit_reg < FIFO_CNT_W'(OUT_FIFO_DEPTH));
    assign credit_next = credit_reg + FIFO_CNT_W'(tick_accept) - FIFO_CNT_W'(pop);
    assign count_next  = count_reg + FIFO_CNT_W'(wr_en) - FIFO_CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            credit_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            count_reg  <= count_next;
            credit_reg <= credit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            buf_mem[wr_ptr_reg] <= wr_data;
    end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import fcpid_pkg::*;

    localparam int     FRAC_BITS     = 12;
    localparam int     SUM_W         = 32;
    localparam longint SUM_MAX       = (64'sd1 <<< (SUM_W - 1)) - 1;
    localparam longint SUM_MIN       = -SUM_MAX - 1;
    localparam int     IDLE_PCT      = 11;
    localparam int     CALM_FROM     = 900;
    localparam int     CALM_TO       = 1150;
    localparam int     HOLD_AT       = 400;
    localparam int     HOLD_CYCLES   = 80;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     PHASE_TICKS   = 320;
    localparam int     CYCLE_LIMIT   = 200000;

    typedef struct {
        logic [CH_W-1:0]         channel;
        logic signed [SPD_W-1:0] setpoint;
        logic signed [SPD_W-1:0] measured;
        logic                    clr;
    } tick_item_t;

    logic clk = 1'b0;
    logic rst_n;

    fcpid_tick_if  tick_bus ();
    fcpid_drive_if drive_bus ();
    fcpid_cfg_if   cfg_bus ();

    four_channel_pid_motor_speed_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .tick  (tick_bus),
        .drive (drive_bus),
        .cfg   (cfg_bus)
    );

    always #5 clk = ~clk;

    // controller copy: register file and per-channel loop state
    logic [GAINS_W-1:0] gain_set [NUM_GAIN_SETS] = '{default: '0};
    logic [DUTY_W-1:0]  duty_lo = '0;
    logic [DUTY_W-1:0]  duty_hi = '1;
    longint             prev_err [NUM_GAIN_SETS] = '{default: 0};
    longint             err_sum [NUM_GAIN_SETS] = '{default: 0};

    logic [GAINS_W-1:0] next_gains [NUM_GAIN_SETS];
    logic [DUTY_W-1:0]  next_lo;
    logic [DUTY_W-1:0]  next_hi;

    tick_item_t pending_ticks [$];
    result_t    expected_drive [$];
    tick_item_t tick_cur;

    int ticks_taken   = 0;
    int beats_checked = 0;
    int mismatches    = 0;
    int settings_used = 0;
    int hold_left     = 0;
    int cycle_count   = 0;

    function automatic result_t pid_tick(tick_item_t t);
        result_t r;
        int      ch;
        longint  sp, pv, err, derr, s, kp, ki, kd, acc, v;
        ch = int'(t.channel);
        sp = longint'(t.setpoint);
        pv = longint'(t.measured);
        err = (sp < 0 ? -sp : sp) - (pv < 0 ? -pv : pv);
        derr = err - prev_err[ch];
        prev_err[ch] = err;
        if (t.clr)
            s = 0;
        else
        begin
            s = err_sum[ch] + err;
            if (s > SUM_MAX)
                s = SUM_MAX;
            if (s < SUM_MIN)
                s = SUM_MIN;
        end
        err_sum[ch] = s;
        kp = longint'($signed(gain_set[ch][KP_LSB +: GAIN_W]));
        ki = longint'($signed(gain_set[ch][KI_LSB +: GAIN_W]));
        kd = longint'($signed(gain_set[ch][KD_LSB +: GAIN_W]));
        acc = kp * err + kd * derr + ki * s;
        // arithmetic shift floors toward minus infinity
        v = acc >>> FRAC_BITS;
        if (v < longint'(duty_lo))
            r.duty = duty_lo;
        else if (v > longint'(duty_hi))
            r.duty = duty_hi;
        else
            r.duty = v[DUTY_W-1:0];
        r.channel = t.channel;
        if (t.setpoint > 0)
            r.direction = DIR_FORWARD;
        else if (t.setpoint < 0)
            r.direction = DIR_REVERSE;
        else
            r.direction = DIR_BRAKE;
        return r;
    endfunction

    function automatic int clip_speed(int x);
        if (x > 32767)
            return 32767;
        if (x < -32768)
            return -32768;
        return x;
    endfunction

    function automatic tick_item_t random_tick();
        tick_item_t t;
        int         sp, pv;
        t.channel = CH_W'($urandom_range(0, 3));
        sp = int'($urandom_range(0, 65535)) - 32768;
        if ($urandom_range(0, 99) < 80)
        begin
            // tracking loop: measured speed close to the target in magnitude
            if ($urandom_range(0, 9) == 0)
                sp = 0;
            pv = clip_speed(sp + int'($urandom_range(0, 400)) - 200);
            if ($urandom_range(0, 4) == 0)
                pv = clip_speed(-pv);
            t.clr = ($urandom_range(0, 19) == 0);
        end
        else
        begin
            pv = int'($urandom_range(0, 65535)) - 32768;
            t.clr = 1'($urandom_range(0, 1));
        end
        t.setpoint = sp[SPD_W-1:0];
        t.measured = pv[SPD_W-1:0];
        return t;
    endfunction

    function automatic logic [GAINS_W-1:0] mild_gains();
        logic [GAIN_W-1:0] p, i, d;
        p = GAIN_W'($urandom_range(0, 16'h4000));
        i = GAIN_W'($urandom_range(0, 16'h0100));
        d = GAIN_W'($urandom_range(0, 16'h2000));
        return {d, i, p};
    endfunction

    task automatic queue_tick(int ch, int sp, int pv, int clr);
        tick_item_t t;
        t.channel = CH_W'(ch);
        t.setpoint = SPD_W'(sp);
        t.measured = SPD_W'(pv);
        t.clr = (clr != 0);
        pending_ticks.push_back(t);
    endtask

    task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        case (idx)
            REG_DUTY_LO: duty_lo = value[DUTY_W-1:0];
            REG_DUTY_HI: duty_hi = value[DUTY_W-1:0];
            default:     gain_set[int'(idx)] = value[GAINS_W-1:0];
        endcase
    endtask

    task automatic apply_setting();
        for (int k = 0; k < NUM_GAIN_SETS; k++)
            cfg_write(cfg_reg_t'(REG_GAINS_CH0 + k), CFG_DATA_W'(next_gains[k]));
        cfg_write(REG_DUTY_LO, CFG_DATA_W'(next_lo));
        cfg_write(REG_DUTY_HI, CFG_DATA_W'(next_hi));
        cfg_bus.valid <= 1'b0;
        settings_used++;
    endtask

    // a beat accepted this edge still shows valid high, so it is not missed
    task automatic drain_and_settle();
        while (pending_ticks.size() != 0 || tick_bus.valid || expected_drive.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : tick_driver
        logic calm;
        if (!rst_n)
        begin
            tick_bus.valid <= 1'b0;
        end
        else
        begin
            if (tick_bus.valid && tick_bus.ready)
            begin
                expected_drive.push_back(pid_tick(tick_cur));
                ticks_taken++;
            end
            if (!tick_bus.valid || tick_bus.ready)
            begin
                calm = (ticks_taken >= CALM_FROM && ticks_taken < CALM_TO);
                if (pending_ticks.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    tick_cur = pending_ticks.pop_front();
                    tick_bus.valid          <= 1'b1;
                    tick_bus.channel        <= tick_cur.channel;
                    tick_bus.setpoint       <= tick_cur.setpoint;
                    tick_bus.measured_speed <= tick_cur.measured;
                    tick_bus.reset_integral <= tick_cur.clr;
                end
                else
                begin
                    tick_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : drive_monitor
        result_t want;
        logic    calm;
        if (!rst_n)
        begin
            drive_bus.ready <= 1'b0;
        end
        else
        begin
            if (drive_bus.valid && drive_bus.ready)
            begin
                if (expected_drive.size() == 0)
                begin
                    $error("drive beat with no tick pending: out_channel %0d duty %0d dir %0d",
                           drive_bus.out_channel, drive_bus.duty, drive_bus.direction);
                    mismatches++;
                end
                else
                begin
                    want = expected_drive.pop_front();
                    if (drive_bus.out_channel !== want.channel)
                    begin
                        $error("out_channel: expected %0d, got %0d",
                               want.channel, drive_bus.out_channel);
                        mismatches++;
                    end
                    if (drive_bus.duty !== want.duty)
                    begin
                        $error("duty: expected %0d, got %0d", want.duty, drive_bus.duty);
                        mismatches++;
                    end
                    if (drive_bus.direction !== want.direction)
                    begin
                        $error("direction: expected %0d, got %0d",
                               want.direction, drive_bus.direction);
                        mismatches++;
                    end
                end
                beats_checked++;
                // stall long enough to back the block up into its input
                if (beats_checked == HOLD_AT)
                    hold_left = HOLD_CYCLES;
            end
            calm = (beats_checked >= CALM_FROM && beats_checked < CALM_TO);
            if (hold_left > 0)
            begin
                hold_left--;
                drive_bus.ready <= 1'b0;
            end
            else
            begin
                drive_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        tick_bus.valid = 1'b0;
        tick_bus.channel = '0;
        tick_bus.setpoint = '0;
        tick_bus.measured_speed = '0;
        tick_bus.reset_integral = 1'b0;
        drive_bus.ready = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = REG_GAINS_CH0;
        cfg_bus.data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset gains are zero, so every duty sits at the lower limit
        queue_tick(0, 0, 0, 0);
        queue_tick(1, 32767, -32768, 0);
        queue_tick(3, -32768, 32767, 1);
        drain_and_settle();

        next_gains[0] = {16'h0800, 16'h0100, 16'h1000};
        next_gains[1] = {16'h0000, 16'h0000, 16'h2000};
        next_gains[2] = {16'h0000, 16'h0100, 16'hF000};
        next_gains[3] = {16'h8000, 16'h7FFF, 16'h7FFF};
        next_lo = 16'd100;
        next_hi = 16'd40000;
        apply_setting();

        queue_tick(0, 1000, 900, 0);
        queue_tick(0, 1000, 950, 0);
        queue_tick(0, -1000, -1100, 0);
        queue_tick(0, 0, 0, 0);
        queue_tick(0, 2000, 0, 1);
        queue_tick(0, 2000, 1990, 0);
        queue_tick(1, 32767, 0, 0);
        queue_tick(1, -32768, 0, 0);
        queue_tick(1, -32768, -32768, 0);
        queue_tick(1, 32767, -32768, 0);
        queue_tick(1, 0, 32767, 1);
        queue_tick(2, 500, 1500, 0);
        queue_tick(2, 500, 600, 0);
        queue_tick(2, 300, 300, 1);
        queue_tick(3, -32768, 0, 0);
        queue_tick(3, -32768, 0, 0);
        queue_tick(3, 0, -32768, 0);
        queue_tick(3, 1, 0, 1);
        queue_tick(3, -1, -1, 0);
        drain_and_settle();

        for (int ph = 0; ph < 5; ph++)
        begin
            for (int k = 0; k < NUM_GAIN_SETS; k++)
                next_gains[k] = mild_gains();
            case (ph)
                0:
                begin
                    next_lo = 16'd0;
                    next_hi = 16'hFFFF;
                end
                1:
                begin
                    next_lo = DUTY_W'($urandom_range(0, 3000));
                    next_hi = DUTY_W'($urandom_range(20000, 65535));
                end
                2:
                begin
                    // full-range gains with an inverted clamp window
                    for (int k = 0; k < NUM_GAIN_SETS; k++)
                        next_gains[k] = GAINS_W'({$urandom, $urandom});
                    next_lo = DUTY_W'($urandom_range(1, 65535));
                    next_hi = DUTY_W'($urandom_range(0, next_lo - 1));
                end
                3:
                begin
                    next_gains[0] = {3{16'h7FFF}};
                    next_gains[1] = {3{16'h8000}};
                    next_gains[2] = {16'h0001, 16'h7FFF, 16'h8000};
                    next_gains[3] = '0;
                    next_lo = DUTY_W'($urandom);
                    next_hi = next_lo;
                end
                default:
                begin
                    next_lo = 16'hFFFF;
                    next_hi = 16'h0000;
                end
            endcase
            apply_setting();
            repeat (PHASE_TICKS) pending_ticks.push_back(random_tick());
            drain_and_settle();
        end

        $display("Covered %0d control ticks on all four channels under %0d register settings,",
                 ticks_taken, settings_used);
        $display("incl. inverted and equal duty limits and extreme gains; %0d beats, %0d errors.",
                 beats_checked, mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
